FILE: rtl/rtc_ep_pkg.sv
// ----------------------------------------------------------------------------
// rtc_ep_pkg
// Shared widths, register indexes and small decode helpers for the clock-chip
// snapshot to epoch-seconds converter.
// ----------------------------------------------------------------------------
package rtc_ep_pkg;

  localparam int ByteW   = 8;
  localparam int EpochW  = 32;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 1;
  localparam int YearW   = 15;   // century*100+year tops out at 25755
  localparam int DaysW   = 25;   // signed day count relative to the epoch
  localparam int HmsW    = 20;   // hour*3600+min*60+sec tops out at 933555

  // register indexes on the write port
  localparam logic [CfgIdxW-1:0] CFG_BCD_MODE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_HOUR_24  = 1'b1;

  // day number of 1970-01-01 counted from 0001-01-01, plus one for the day offset
  localparam logic [EpochW-1:0] EpochDayBias = 32'd719163;
  localparam logic [EpochW-1:0] YearZeroDays = 32'hFFFF_FE92;  // -366

  localparam logic [EpochW-1:0] SecPerDay = 32'd86400;

  // packed bcd or plain binary byte
  function automatic logic [ByteW-1:0] dec_byte(input logic [ByteW-1:0] b,
                                                input logic bcd);
    logic [ByteW-1:0] res;
    if (bcd) begin
      res = ByteW'(b[7:4]) * ByteW'(10) + ByteW'(b[3:0]);
    end else begin
      res = b;
    end
    return res;
  endfunction

  // days in the months before the given month of a common year
  function automatic logic [8:0] month_cum(input logic [3:0] m);
    logic [8:0] res;
    case (m)
      4'd0, 4'd1: res = 9'd0;
      4'd2:       res = 9'd31;
      4'd3:       res = 9'd59;
      4'd4:       res = 9'd90;
      4'd5:       res = 9'd120;
      4'd6:       res = 9'd151;
      4'd7:       res = 9'd181;
      4'd8:       res = 9'd212;
      4'd9:       res = 9'd243;
      4'd10:      res = 9'd273;
      4'd11:      res = 9'd304;
      default:    res = 9'd334;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/rtc_fields_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// rtc_fields_to_epoch_seconds
// Converts one snapshot of raw clock-chip bytes into seconds since 1970-01-01.
//
//   channel   | signals                                  | direction
//   ----------+------------------------------------------+----------
//   request   | start_i, busy_o, raw_*_i                 | in
//   result    | done_o, epoch_seconds_o                  | out
//   config    | cfg_we_i, cfg_idx_i, cfg_wdata_i         | in
//
// seven register stages; a request taken at one edge shows its result on
// done_o once it has passed through all of them, for one cycle
// a new request can be taken every cycle, busy_o stays low
// the latency is set by the stage chain: decode, hour fix, divide by 100,
// calendar terms, day sum, day-to-second multiply, final add
// reset clears the valid bits and sets both mode registers to 1
// ----------------------------------------------------------------------------
module rtc_fields_to_epoch_seconds (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [rtc_ep_pkg::ByteW-1:0]    raw_second_i,
  input  logic [rtc_ep_pkg::ByteW-1:0]    raw_minute_i,
  input  logic [rtc_ep_pkg::ByteW-1:0]    raw_hour_i,
  input  logic [rtc_ep_pkg::ByteW-1:0]    raw_day_i,
  input  logic [rtc_ep_pkg::ByteW-1:0]    raw_month_i,
  input  logic [rtc_ep_pkg::ByteW-1:0]    raw_year_i,
  input  logic [rtc_ep_pkg::ByteW-1:0]    raw_century_i,
  output logic                            done_o,
  output logic [rtc_ep_pkg::EpochW-1:0]   epoch_seconds_o,
  input  logic                            cfg_we_i,
  input  logic [rtc_ep_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rtc_ep_pkg::CfgW-1:0]     cfg_wdata_i
);
  import rtc_ep_pkg::*;

  // configuration
  logic bcd_q, bcd_d;
  logic h24_q, h24_d;

  always_comb begin
    bcd_d = bcd_q;
    h24_d = h24_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BCD_MODE: bcd_d = cfg_wdata_i[0];
        CFG_HOUR_24:  h24_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_q <= 1'b1;
      h24_q <= 1'b1;
    end else begin
      bcd_q <= bcd_d;
      h24_q <= h24_d;
    end
  end

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // valid bits
  logic [5:0] v_q, v_d;
  logic       done_q, done_d;

  assign v_d    = {v_q[4:0], accept};
  assign done_d = v_q[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      done_q <= 1'b0;
    end else begin
      v_q    <= v_d;
      done_q <= done_d;
    end
  end

  // stage 1: byte decode
  logic [ByteW-1:0] sec1_q, min1_q, hr1_q, day1_q, yr1_q, cen1_q;
  logic [ByteW-1:0] sec1_d, min1_d, hr1_d, day1_d, yr1_d, cen1_d, mon_dec;
  logic [3:0]       mon1_q, mon1_d;
  logic             pm1_q, pm1_d, h24_1_q, h24_1_d;

  always_comb begin
    sec1_d  = dec_byte(raw_second_i, bcd_q);
    min1_d  = dec_byte(raw_minute_i, bcd_q);
    day1_d  = dec_byte(raw_day_i, bcd_q);
    yr1_d   = dec_byte(raw_year_i, bcd_q);
    cen1_d  = dec_byte(raw_century_i, bcd_q);
    mon_dec = dec_byte(raw_month_i, bcd_q);
    mon1_d  = (mon_dec > ByteW'(12)) ? 4'd12 : mon_dec[3:0];
    // pm flag is stripped before decode in 12-hour mode
    hr1_d   = h24_q ? dec_byte(raw_hour_i, bcd_q)
                    : dec_byte({1'b0, raw_hour_i[6:0]}, bcd_q);
    pm1_d   = raw_hour_i[7];
    h24_1_d = h24_q;
  end

  always_ff @(posedge clk_i) begin
    sec1_q  <= sec1_d;
    min1_q  <= min1_d;
    hr1_q   <= hr1_d;
    day1_q  <= day1_d;
    mon1_q  <= mon1_d;
    yr1_q   <= yr1_d;
    cen1_q  <= cen1_d;
    pm1_q   <= pm1_d;
    h24_1_q <= h24_1_d;
  end

  // stage 2: full year, 12-hour fix
  logic [YearW-1:0] year2_q, year2_d;
  logic [ByteW-1:0] hour2_q, hour2_d;
  logic [ByteW-1:0] sec2_q, min2_q, day2_q;
  logic [3:0]       mon2_q;
  logic [12:0]      prod12;
  logic [3:0]       q12;
  logic [6:0]       r12;

  always_comb begin
    year2_d = YearW'(cen1_q) * YearW'(100) + YearW'(yr1_q);
    // h mod 12 by reciprocal, exact for h below 128
    prod12  = 13'(hr1_q[6:0]) * 13'd43;
    q12     = prod12[12:9];
    r12     = hr1_q[6:0] - 7'(q12) * 7'd12;
    if (h24_1_q) begin
      hour2_d = hr1_q;
    end else begin
      hour2_d = ByteW'(r12[3:0]) + (pm1_q ? ByteW'(12) : ByteW'(0));
    end
  end

  always_ff @(posedge clk_i) begin
    year2_q <= year2_d;
    hour2_q <= hour2_d;
    sec2_q  <= sec1_q;
    min2_q  <= min1_q;
    day2_q  <= day1_q;
    mon2_q  <= mon1_q;
  end

  // stage 3: year / 100, time of day
  logic [YearW-1:0] year3_q;
  logic [8:0]       q100_3_q, q100_3_d;
  logic [HmsW-1:0]  hms3_q, hms3_d;
  logic [ByteW-1:0] day3_q;
  logic [3:0]       mon3_q;
  logic [27:0]      prod100;

  always_comb begin
    // exact for years up to 25755
    prod100  = 28'(year2_q) * 28'd5243;
    q100_3_d = prod100[27:19];
    hms3_d   = HmsW'(hour2_q) * HmsW'(3600) + HmsW'(min2_q) * HmsW'(60)
             + HmsW'(sec2_q);
  end

  always_ff @(posedge clk_i) begin
    year3_q  <= year2_q;
    q100_3_q <= q100_3_d;
    hms3_q   <= hms3_d;
    day3_q   <= day2_q;
    mon3_q   <= mon2_q;
  end

  // stage 4: leap rule and calendar terms
  logic [YearW-1:0] p4_q, p4_d, r100;
  logic [8:0]       qp4_q, qp4_d, cum4_q, cum4_d;
  logic             yzero4_q, yzero4_d;
  logic [HmsW-1:0]  hms4_q;
  logic [ByteW-1:0] day4_q;
  logic             cent_yr, leap;

  always_comb begin
    r100     = year3_q - YearW'(q100_3_q) * YearW'(100);
    cent_yr  = (r100 == '0);
    leap     = ((year3_q[1:0] == 2'd0) && !cent_yr)
            || (cent_yr && (q100_3_q[1:0] == 2'd0));
    yzero4_d = (year3_q == '0);
    p4_d     = year3_q - YearW'(1);
    // (year-1)/100 steps back only on a century year
    qp4_d    = (cent_yr && !yzero4_d) ? q100_3_q - 9'd1 : q100_3_q;
    cum4_d   = month_cum(mon3_q) + ((leap && (mon3_q > 4'd2)) ? 9'd1 : 9'd0);
  end

  always_ff @(posedge clk_i) begin
    p4_q     <= p4_d;
    qp4_q    <= qp4_d;
    cum4_q   <= cum4_d;
    yzero4_q <= yzero4_d;
    hms4_q   <= hms3_q;
    day4_q   <= day3_q;
  end

  // stage 5: day count since the epoch
  logic [DaysW-1:0]  days5_q;
  logic [EpochW-1:0] base, days_sum;
  logic [HmsW-1:0]   hms5_q;

  always_comb begin
    if (yzero4_q) begin
      base = YearZeroDays;
    end else begin
      base = EpochW'(p4_q) * EpochW'(365) + EpochW'(p4_q[YearW-1:2])
           - EpochW'(qp4_q) + EpochW'(qp4_q[8:2]);
    end
    days_sum = base + EpochW'(cum4_q) + EpochW'(day4_q) - EpochDayBias;
  end

  always_ff @(posedge clk_i) begin
    days5_q <= days_sum[DaysW-1:0];
    hms5_q  <= hms4_q;
  end

  // stage 6: days to seconds, wrapping
  logic [EpochW-1:0] prod6_q, prod6_d;
  logic [HmsW-1:0]   hms6_q;

  assign prod6_d = {{(EpochW-DaysW){days5_q[DaysW-1]}}, days5_q} * SecPerDay;

  always_ff @(posedge clk_i) begin
    prod6_q <= prod6_d;
    hms6_q  <= hms5_q;
  end

  // stage 7: output register
  logic [EpochW-1:0] epoch_q, epoch_d;

  assign epoch_d = prod6_q + EpochW'(hms6_q);

  always_ff @(posedge clk_i) begin
    epoch_q <= epoch_d;
  end

  assign done_o          = done_q;
  assign epoch_seconds_o = epoch_q;

endmodule

FILE: rtl/rtc_ep_chk.sv
// ----------------------------------------------------------------------------
// rtc_ep_chk
// Port-level checks on request-to-result timing and repeatability.
// ----------------------------------------------------------------------------
module rtc_ep_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [7:0]  raw_second_i,
  input logic [7:0]  raw_minute_i,
  input logic [7:0]  raw_hour_i,
  input logic [7:0]  raw_day_i,
  input logic [7:0]  raw_month_i,
  input logic [7:0]  raw_year_i,
  input logic [7:0]  raw_century_i,
  input logic        done_o,
  input logic [31:0] epoch_seconds_o,
  input logic        cfg_we_i,
  input logic [0:0]  cfg_idx_i,
  input logic [0:0]  cfg_wdata_i
);

  logic req;
  logic [55:0] snap;

  assign req  = start_i && !busy_o;
  assign snap = {raw_second_i, raw_minute_i, raw_hour_i, raw_day_i,
                 raw_month_i, raw_year_i, raw_century_i};

  // every request gives a result on done_o
  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req |-> ##7 done_o)
    else $error("request without result");

  // no result without an earlier request
  a_done_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req, 7))
    else $error("result without request");

  // two equal back-to-back requests under the same modes give equal results
  a_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req && $past(req) && $stable(snap) && !$past(cfg_we_i))
      |-> ##7 $stable(epoch_seconds_o))
    else $error("equal requests gave different results");

endmodule

bind rtc_fields_to_epoch_seconds rtc_ep_chk u_rtc_ep_chk (.*);
